// ----- src/householder_lq_decomposition_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Householder LQ unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HOUSEHOLDER_LQ_DECOMPOSITION_UNIT_DEFINES_SVH
`define HOUSEHOLDER_LQ_DECOMPOSITION_UNIT_DEFINES_SVH

// same-cycle implication
`define HLQ_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hlq: same-cycle check failed");

// next-cycle implication
`define HLQ_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hlq: next-cycle check failed");

`endif

// ----- src/hlq_pkg.sv -----
// ----------------------------------------------------------------------------
// Householder LQ package
// Sizes, widths, beat types, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package hlq_pkg;

    localparam int MAX_ROWS  = 4;
    localparam int MAX_COLS  = 4;
    localparam int IDX_W     = 2;
    localparam int DIM_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int VAL_W     = 32;
    localparam int THR_W     = 16;
    localparam int MAG_W     = 33;
    localparam int WIDE_W    = 43;

    localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sd65536;

    // shared multiplier: 68 x 33 bits, 8 multiplier bits a step
    localparam int MUL_A_W    = 68;
    localparam int MUL_B_W    = 33;
    localparam int MUL_CHUNK  = 8;
    localparam int MUL_STEPS  = (MUL_B_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int MUL_B_PAD  = MUL_STEPS * MUL_CHUNK;
    localparam int MUL_SUM_W  = MUL_A_W + MUL_CHUNK + 1;
    localparam int MUL_CNT_W  = 3;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // restoring divider
    localparam int DEN_W      = 66;
    localparam int QUO_W      = 64;
    localparam int DIV_STEPS  = PROD_W;
    localparam int DIV_CNT_W  = 7;

    // square root
    localparam int RAD_W      = 65;
    localparam int ROOT_W     = 33;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQRT_CNT_W = 6;

    localparam int ACC_W      = 68;
    localparam int CAP_W      = 41;
    localparam logic [CAP_W-1:0] CORR_CAP = 41'd1 << 40;

    typedef enum logic [1:0] {
        CFG_ROW_COUNT = 2'd0,
        CFG_COL_COUNT = 2'd1,
        CFG_TINY      = 2'd2
    } hlq_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]        elem_row;
        logic [IDX_W-1:0]        elem_col;
        logic signed [VAL_W-1:0] elem_value;
        logic                    load_done;
    } in_item_t;

    typedef struct packed {
        logic                    which_matrix;
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic [DIM_W-1:0]        rank;
        logic                    final_result;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT_Q,
        S_DIAG,
        S_DIAG_CHK,
        S_SQ_RD,
        S_SQ_MUL,
        S_SQ_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_TEST,
        S_DEN_WAIT,
        S_VEC_BEGIN,
        S_DOT_RD,
        S_DOT_MUL,
        S_DOT_WAIT,
        S_UPD_MUL,
        S_UPD_MWAIT,
        S_UPD_DWAIT,
        S_UPD_WR,
        S_VEC_NEXT,
        S_FIN_DIAG,
        S_FIN_ZERO,
        S_STEP_NEXT,
        S_EMIT_RD,
        S_EMIT_OUT
    } hlq_state_t;

endpackage

// ----- src/hlq_mul.sv -----
// ----------------------------------------------------------------------------
// Householder LQ shared multiplier
// Unsigned 68 x 33 multiply, one 8-bit multiplier digit per cycle.
// ----------------------------------------------------------------------------
module hlq_mul import hlq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [PROD_W-1:0]  prod
);

    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_B_PAD-1:0] b_reg;
    logic [MUL_A_W:0]     hi_reg;
    logic [MUL_B_PAD-1:0] lo_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [MUL_SUM_W-1:0] sum;

    assign sum = MUL_SUM_W'(hi_reg)
               + MUL_SUM_W'(a_reg) * MUL_SUM_W'(b_reg[MUL_CHUNK-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= MUL_B_PAD'(b);
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (run_reg)
        begin
            hi_reg <= sum[MUL_SUM_W-1:MUL_CHUNK];
            lo_reg <= {sum[MUL_CHUNK-1:0], lo_reg[MUL_B_PAD-1:MUL_CHUNK]};
            b_reg  <= b_reg >> MUL_CHUNK;
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[PROD_W-MUL_B_PAD-1:0], lo_reg};

endmodule

// ----- src/hlq_div.sv -----
// ----------------------------------------------------------------------------
// Householder LQ divider
// Restoring division, one quotient bit per cycle, low 64 quotient bits kept.
// ----------------------------------------------------------------------------
module hlq_div import hlq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUO_W-1:0]  quot
);

    logic [PROD_W-1:0]    num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, num_reg[PROD_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            q_reg   <= {q_reg[QUO_W-2:0], fits};
            num_reg <= num_reg << 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- src/hlq_sqrt.sv -----
// ----------------------------------------------------------------------------
// Householder LQ square root
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module hlq_sqrt import hlq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  rad,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [2*ROOT_W-1:0]   rad_reg;
    logic [ROOT_W+1:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [ROOT_W+3:0]     rem_sh;
    logic [ROOT_W+3:0]     trial;
    logic [ROOT_W+3:0]     rem_sub;
    logic                  fits;

    assign rem_sh  = {rem_reg, rad_reg[2*ROOT_W-1:2*ROOT_W-2]};
    assign trial   = (ROOT_W+4)'({root_reg, 2'b01});
    assign rem_sub = rem_sh - trial;
    assign fits    = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= (2*ROOT_W)'(rad);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= fits ? rem_sub[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
            rad_reg  <= rad_reg << 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- src/householder_lq_decomposition_unit.sv -----
// ----------------------------------------------------------------------------
// Householder LQ decomposition unit
// Loads a matrix beat by beat, factors it as L * Q with Householder
// reflections in Q16.16, then streams L and Q out with the rank.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   load     | start / busy         | item   (in_item_t)
//   result   | result_valid strobe  | result (out_item_t)
//   config   | cfg_write            | cfg_index, cfg_data
//
// A load beat without load_done writes its element; the unit stays idle.
// The final beat starts a factorisation: Q set-up writes the identity to all
// 16 Q entries, then each element updated takes a dot-product term from the
// shared multiplier (5 steps), then a multiply and the bit-serial divider
// (101 steps) for the update itself; results follow from S_EMIT_RD/S_EMIT_OUT.
// busy rises after the final load beat, holds through the last result beat.
// Reset is asynchronous, active low; the receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "householder_lq_decomposition_unit_defines.svh"

module householder_lq_decomposition_unit import hlq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    output logic             result_valid,
    output out_item_t        result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [THR_W-1:0] cfg_data
);

    hlq_state_t state_reg, state_next;

    logic [DIM_W-1:0] row_count_reg, col_count_reg;
    logic [THR_W-1:0] tiny_reg;

    logic [DIM_W-1:0]  i_reg, k_reg, j_reg, rank_reg;
    logic              vsel_reg;
    logic [ADDR_W:0]   init_reg;
    logic              em_which_reg;
    logic [IDX_W-1:0]  em_r_reg, em_c_reg;

    logic signed [VAL_W-1:0] diag_reg;
    logic [RAD_W-1:0]        sq_reg;
    logic [ROOT_W-1:0]       n_reg;
    logic [DEN_W-1:0]        den_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    psign_reg;
    logic [MAG_W-1:0]        vmag_reg [MAX_COLS];
    logic                    vneg_reg [MAX_COLS];

    logic signed [VAL_W-1:0] w_mem [MEM_DEPTH];
    logic signed [VAL_W-1:0] q_mem [MEM_DEPTH];
    logic signed [VAL_W-1:0] w_rd_reg, q_rd_reg;

    logic [ADDR_W-1:0]       rd_addr, wr_addr, x_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic                    w_we, q_we;

    logic [DIM_W-1:0] rows_eff, cols_eff, size_eff, len, ik;
    logic             k_last;

    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_prod;
    logic               div_start, div_done;
    logic [QUO_W-1:0]   quot;
    logic               sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]  root;

    logic signed [VAL_W-1:0] x_data;
    logic [MAG_W-1:0]        dsmag;
    logic                    step_tiny;
    logic [ACC_W-1:0]        dm;
    logic [CAP_W-1:0]        capped;
    logic signed [WIDE_W-1:0] x_new_wide;
    logic signed [WIDE_W-1:0] s_wide;
    logic                    em_last;

    function automatic logic [MAG_W-1:0] mag33(input logic signed [VAL_W-1:0] x);
        logic signed [MAG_W-1:0] e;
        e = MAG_W'(x);
        return x[VAL_W-1] ? MAG_W'(-e) : MAG_W'(e);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        if (x > WIDE_W'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        else if (x < -WIDE_W'(33'sh0_8000_0000))
            return 32'sh8000_0000;
        else
            return x[VAL_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] mat_addr(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c);
        return {r[IDX_W-1:0], c[IDX_W-1:0]};
    endfunction

    function automatic logic dneg_xor();
        return acc_reg[ACC_W-1] ^ vneg_reg[k_reg[IDX_W-1:0]];
    endfunction

    // size clamping
    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = DIM_W'(1);
        else if (row_count_reg > DIM_W'(MAX_ROWS))
            rows_eff = DIM_W'(MAX_ROWS);
        else
            rows_eff = row_count_reg;
        if (col_count_reg == '0)
            cols_eff = DIM_W'(1);
        else if (col_count_reg > DIM_W'(MAX_COLS))
            cols_eff = DIM_W'(MAX_COLS);
        else
            cols_eff = col_count_reg;
        size_eff = (rows_eff < cols_eff) ? rows_eff : cols_eff;
    end

    assign len    = cols_eff - i_reg;
    assign ik     = i_reg + k_reg;
    assign k_last = (k_reg + 1'b1) == len;
    assign x_addr = vsel_reg ? mat_addr(j_reg, ik) : mat_addr(ik, j_reg);
    assign x_data = vsel_reg ? w_rd_reg : q_rd_reg;

    assign dsmag     = MAG_W'(n_reg) + mag33(diag_reg);
    assign step_tiny = (MAG_W'(n_reg) < MAG_W'(tiny_reg)) || (dsmag < MAG_W'(tiny_reg));
    assign dm        = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign capped    = (quot > QUO_W'(CORR_CAP)) ? CORR_CAP : quot[CAP_W-1:0];

    always_comb
    begin
        if (dneg_xor())
            x_new_wide = WIDE_W'(x_data) + WIDE_W'(capped);
        else
            x_new_wide = WIDE_W'(x_data) - WIDE_W'(capped);
    end

    assign s_wide = (diag_reg > 0) ? -WIDE_W'(n_reg) : WIDE_W'(n_reg);

    assign em_last = em_which_reg && ({1'b0, em_r_reg} == cols_eff - 1'b1)
                                  && ({1'b0, em_c_reg} == cols_eff - 1'b1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start && item.load_done)
                    state_next = S_INIT_Q;
            S_INIT_Q:
                if (init_reg == (ADDR_W+1)'(MEM_DEPTH - 1))
                    state_next = S_DIAG;
            S_DIAG:
                state_next = (i_reg == size_eff) ? S_EMIT_RD : S_DIAG_CHK;
            S_DIAG_CHK:
                state_next = (w_rd_reg == '0) ? S_STEP_NEXT : S_SQ_RD;
            S_SQ_RD:
                state_next = S_SQ_MUL;
            S_SQ_MUL:
                state_next = S_SQ_WAIT;
            S_SQ_WAIT:
                if (mul_done)
                    state_next = k_last ? S_SQRT_GO : S_SQ_RD;
            S_SQRT_GO:
                state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:
                if (sqrt_done)
                    state_next = S_TEST;
            S_TEST:
                state_next = step_tiny ? S_STEP_NEXT : S_DEN_WAIT;
            S_DEN_WAIT:
                if (mul_done)
                    state_next = S_VEC_BEGIN;
            S_VEC_BEGIN:
                state_next = S_DOT_RD;
            S_DOT_RD:
                state_next = S_DOT_MUL;
            S_DOT_MUL:
                state_next = S_DOT_WAIT;
            S_DOT_WAIT:
                if (mul_done)
                    state_next = k_last ? S_UPD_MUL : S_DOT_RD;
            S_UPD_MUL:
                state_next = S_UPD_MWAIT;
            S_UPD_MWAIT:
                if (mul_done)
                    state_next = S_UPD_DWAIT;
            S_UPD_DWAIT:
                if (div_done)
                    state_next = S_UPD_WR;
            S_UPD_WR:
                state_next = k_last ? S_VEC_NEXT : S_UPD_MUL;
            S_VEC_NEXT:
            begin
                if (!vsel_reg)
                begin
                    if (j_reg != cols_eff - 1'b1)
                        state_next = S_VEC_BEGIN;
                    else if (rows_eff - 1'b1 > i_reg)
                        state_next = S_VEC_BEGIN;
                    else
                        state_next = S_FIN_DIAG;
                end
                else
                    state_next = (j_reg - 1'b1 > i_reg) ? S_VEC_BEGIN : S_FIN_DIAG;
            end
            S_FIN_DIAG:
                state_next = S_FIN_ZERO;
            S_FIN_ZERO:
                if (k_reg == len)
                    state_next = S_STEP_NEXT;
            S_STEP_NEXT:
                state_next = S_DIAG;
            S_EMIT_RD:
                state_next = S_EMIT_OUT;
            S_EMIT_OUT:
                state_next = em_last ? S_IDLE : S_EMIT_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        rd_addr      = '0;
        wr_addr      = '0;
        wr_data      = '0;
        w_we         = 1'b0;
        q_we         = 1'b0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        result_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                w_we    = start;
                wr_addr = {item.elem_row, item.elem_col};
                wr_data = item.elem_value;
            end
            S_INIT_Q:
            begin
                q_we    = 1'b1;
                wr_addr = init_reg[ADDR_W-1:0];
                wr_data = (init_reg[ADDR_W-1:IDX_W] == init_reg[IDX_W-1:0]) ? ONE_Q16 : '0;
            end
            S_DIAG:
                rd_addr = mat_addr(i_reg, i_reg);
            S_SQ_RD:
                rd_addr = mat_addr(i_reg, ik);
            S_SQ_MUL:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(mag33(w_rd_reg));
                mul_b     = mag33(w_rd_reg);
            end
            S_SQRT_GO:
                sqrt_start = 1'b1;
            S_TEST:
            begin
                mul_start = !step_tiny;
                mul_a     = MUL_A_W'(n_reg);
                mul_b     = dsmag;
            end
            S_DOT_RD:
                rd_addr = x_addr;
            S_DOT_MUL:
            begin
                rd_addr   = x_addr;
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(mag33(x_data));
                mul_b     = vmag_reg[k_reg[IDX_W-1:0]];
            end
            S_UPD_MUL:
            begin
                mul_start = 1'b1;
                mul_a     = dm;
                mul_b     = vmag_reg[k_reg[IDX_W-1:0]];
            end
            S_UPD_MWAIT:
                div_start = mul_done;
            S_UPD_DWAIT:
                rd_addr = x_addr;
            S_UPD_WR:
            begin
                rd_addr = x_addr;
                wr_addr = x_addr;
                wr_data = sat32(x_new_wide);
                w_we    = vsel_reg;
                q_we    = !vsel_reg;
            end
            S_FIN_DIAG:
            begin
                w_we    = 1'b1;
                wr_addr = mat_addr(i_reg, i_reg);
                wr_data = sat32(s_wide);
            end
            S_FIN_ZERO:
            begin
                w_we    = (k_reg != len);
                wr_addr = mat_addr(i_reg, ik);
            end
            S_EMIT_RD:
                rd_addr = {em_r_reg, em_c_reg};
            S_EMIT_OUT:
                result_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    assign busy                = (state_reg != S_IDLE);
    assign result.which_matrix = em_which_reg;
    assign result.out_row      = em_r_reg;
    assign result.out_col      = em_c_reg;
    assign result.out_value    = em_which_reg ? q_rd_reg : w_rd_reg;
    assign result.rank         = rank_reg;
    assign result.final_result = em_last;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= DIM_W'(4);
            col_count_reg <= DIM_W'(4);
            tiny_reg      <= THR_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data[DIM_W-1:0];
                CFG_COL_COUNT: col_count_reg <= cfg_data[DIM_W-1:0];
                CFG_TINY:      tiny_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // sequencer counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            vsel_reg     <= 1'b0;
            rank_reg     <= '0;
            init_reg     <= '0;
            em_which_reg <= 1'b0;
            em_r_reg     <= '0;
            em_c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    init_reg <= '0;
                    i_reg    <= '0;
                    rank_reg <= '0;
                end
                S_INIT_Q:
                    init_reg <= init_reg + 1'b1;
                S_DIAG:
                begin
                    em_which_reg <= 1'b0;
                    em_r_reg     <= '0;
                    em_c_reg     <= '0;
                end
                S_DIAG_CHK:
                    k_reg <= '0;
                S_SQ_WAIT:
                    if (mul_done)
                        k_reg <= k_last ? '0 : k_reg + 1'b1;
                S_DEN_WAIT:
                begin
                    vsel_reg <= 1'b0;
                    j_reg    <= '0;
                end
                S_VEC_BEGIN:
                    k_reg <= '0;
                S_DOT_WAIT:
                    if (mul_done)
                        k_reg <= k_last ? '0 : k_reg + 1'b1;
                S_UPD_WR:
                    k_reg <= k_reg + 1'b1;
                S_VEC_NEXT:
                begin
                    if (!vsel_reg)
                    begin
                        if (j_reg != cols_eff - 1'b1)
                            j_reg <= j_reg + 1'b1;
                        else
                        begin
                            vsel_reg <= 1'b1;
                            j_reg    <= rows_eff - 1'b1;
                        end
                    end
                    else
                        j_reg <= j_reg - 1'b1;
                end
                S_FIN_DIAG:
                begin
                    rank_reg <= rank_reg + 1'b1;
                    k_reg    <= DIM_W'(1);
                end
                S_FIN_ZERO:
                    if (k_reg != len)
                        k_reg <= k_reg + 1'b1;
                S_STEP_NEXT:
                    i_reg <= i_reg + 1'b1;
                S_EMIT_OUT:
                begin
                    if ({1'b0, em_c_reg} == cols_eff - 1'b1)
                    begin
                        em_c_reg <= '0;
                        if (!em_which_reg && ({1'b0, em_r_reg} == rows_eff - 1'b1))
                        begin
                            em_which_reg <= 1'b1;
                            em_r_reg     <= '0;
                        end
                        else
                            em_r_reg <= em_r_reg + 1'b1;
                    end
                    else
                        em_c_reg <= em_c_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // arithmetic state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_DIAG_CHK:
            begin
                diag_reg <= w_rd_reg;
                sq_reg   <= '0;
            end
            S_SQ_MUL:
            begin
                vmag_reg[k_reg[IDX_W-1:0]] <= mag33(w_rd_reg);
                vneg_reg[k_reg[IDX_W-1:0]] <= w_rd_reg[VAL_W-1];
            end
            S_SQ_WAIT:
                if (mul_done)
                    sq_reg <= sq_reg + mul_prod[RAD_W-1:0];
            S_SQRT_WAIT:
                if (sqrt_done)
                    n_reg <= root;
            S_TEST:
            begin
                vmag_reg[0] <= dsmag;
                vneg_reg[0] <= diag_reg[VAL_W-1];
            end
            S_DEN_WAIT:
                if (mul_done)
                    den_reg <= mul_prod[DEN_W-1:0];
            S_VEC_BEGIN:
                acc_reg <= '0;
            S_DOT_MUL:
                psign_reg <= x_data[VAL_W-1] ^ vneg_reg[k_reg[IDX_W-1:0]];
            S_DOT_WAIT:
                if (mul_done)
                begin
                    if (psign_reg)
                        acc_reg <= acc_reg - $signed({1'b0, mul_prod[ACC_W-2:0]});
                    else
                        acc_reg <= acc_reg + $signed({1'b0, mul_prod[ACC_W-2:0]});
                end
            default:
            begin
            end
        endcase
    end

    // matrix stores
    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[wr_addr] <= wr_data;
        w_rd_reg <= w_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[wr_addr] <= wr_data;
        q_rd_reg <= q_mem[rd_addr];
    end

    hlq_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    hlq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mul_prod),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    hlq_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sq_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    `HLQ_ASSERT_NOW(a_result_busy, result_valid, busy)
    `HLQ_ASSERT_NEXT(a_final_idle, result_valid && result.final_result, !busy)
    `HLQ_ASSERT_NEXT(a_plain_load, start && !busy && !item.load_done, !busy)
    `HLQ_ASSERT_NOW(a_rank_bound, result_valid, result.rank <= rows_eff)

endmodule
